// File: rtl/core/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int KIND_W = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam cmd_t CMD_PUT   = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  localparam kind_t KIND_ECHO  = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_BS  = 8'h08;
  localparam byte_t CH_TAB = 8'h09;
  localparam byte_t CH_SP  = 8'h20;
  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_NUL = 8'h00;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic plan;
    logic row_sel;
    logic sweep_step;
    logic write_cell;
    logic scroll_set;
    logic mem_read;
    logic rd_load;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic put_write;
    logic put_scroll;
    logic scroll_pend;
    logic row_zero;
    logic sweep_done;
    logic out_free;
    logic q_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/tcc_if.sv
`default_nettype none

interface tcc_in_if;
  import tcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BYTE_W-1:0] byte_value;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic              last;

  modport source (output valid, result_kind, byte_value, cursor_row, cursor_col, last,
                  input ready);
  modport sink   (input valid, result_kind, byte_value, cursor_row, cursor_col, last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/tcc_ctrl.sv
`default_nettype none

module tcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tcc_pkg::dp_sts_t  sts,
  output tcc_pkg::dp_cmd_t       cmd
);
  import tcc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_ROWSEL   = 10'b0000000100,
    S_MAT      = 10'b0000001000,
    S_WRITE    = 10'b0000010000,
    S_SCRL_SET = 10'b0000100000,
    S_SCROLL   = 10'b0001000000,
    S_RREAD    = 10'b0010000000,
    S_RDATA    = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.plan = 1'b1;
        unique case (sts.cmd)
          CMD_PUT: begin
            if (sts.put_write)       state_nxt = S_ROWSEL;
            else if (sts.put_scroll) state_nxt = S_SCRL_SET;
            else                     state_nxt = S_EMIT;
          end
          CMD_CLEAR: state_nxt = S_EMIT;
          CMD_READ:  state_nxt = S_ROWSEL;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_ROWSEL: begin
        cmd.row_sel = 1'b1;
        if (sts.cmd == CMD_READ) state_nxt = S_RREAD;
        else if (sts.row_zero)   state_nxt = S_MAT;
        else                     state_nxt = S_WRITE;
      end
      S_MAT: begin
        // row still reads as cleared: fill it with zeros before the cell write
        cmd.sweep_step = 1'b1;
        if (sts.sweep_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_cell = 1'b1;
        state_nxt      = sts.scroll_pend ? S_SCRL_SET : S_EMIT;
      end
      S_SCRL_SET: begin
        cmd.scroll_set = 1'b1;
        state_nxt      = S_SCROLL;
      end
      S_SCROLL: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_done) state_nxt = S_EMIT;
      end
      S_RREAD: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_RDATA;
      end
      S_RDATA: begin
        cmd.rd_load = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.q_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcc_dp.sv
`default_nettype none

module tcc_dp #(
  parameter int COLS = tcc_pkg::DEF_COLS,
  parameter int ROWS = tcc_pkg::DEF_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tcc_pkg::dp_cmd_t              cmd,
  output tcc_pkg::dp_sts_t                   sts,
  input  wire logic [tcc_pkg::CMD_W-1:0]     in_command,
  input  wire logic [tcc_pkg::BYTE_W-1:0]    in_char_code,
  input  wire logic [tcc_pkg::ROW_W-1:0]     in_read_row,
  input  wire logic [tcc_pkg::COL_W-1:0]     in_read_col,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [tcc_pkg::KIND_W-1:0]         out_result_kind,
  output logic [tcc_pkg::BYTE_W-1:0]         out_byte_value,
  output logic [tcc_pkg::ROW_W-1:0]          out_cursor_row,
  output logic [tcc_pkg::COL_W-1:0]          out_cursor_col,
  output logic                               out_last
);
  import tcc_pkg::*;

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  // latched input item
  cmd_t             cmd_r;
  byte_t            ch_r;
  logic [ROW_W-1:0] rrow_r;
  logic [COL_W-1:0] rcol_r;

  // cursor, top-of-screen row in the ring, per-row "reads as zero" flags
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   base_r, base_nxt;
  logic [ROWS-1:0] zero_row_r, zero_row_nxt;

  // access target and sweep
  logic [RW-1:0] phys_r;
  logic [CW-1:0] tcol_r;
  byte_t         wdata_r;
  logic          scroll_r;
  logic          oor_r;
  logic [AW-1:0] rowbase_r;
  logic [CW-1:0] sweep_cnt_r;
  logic [RW-1:0] sweep_row_r;
  byte_t         fill_r;
  byte_t         rdata_r;
  byte_t         mem [DEPTH];

  // pending result bytes of the current item
  byte_t       q_r [3];
  kind_t       qkind_r;
  logic [1:0]  qcnt_r;
  logic [1:0]  qidx_r;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r;
  byte_t       out_byte_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic        out_last_r;

  // put plan
  logic          p_write, p_scroll;
  logic [RW-1:0] p_trow, p_nrow;
  logic [CW-1:0] p_tcol, p_ncol;
  byte_t         p_data, p_q0, p_q1, p_q2;
  logic [1:0]    p_cnt;
  logic [RW-1:0] lrow;
  logic [RW:0]   psum;
  logic [RW-1:0] phys_c;
  logic          sweep_done;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  byte_t         mem_wdata;

  always_comb begin
    p_write  = 1'b0;
    p_scroll = 1'b0;
    p_trow   = row_r;
    p_tcol   = col_r;
    p_nrow   = row_r;
    p_ncol   = col_r;
    p_data   = ch_r;
    p_q0     = ch_r;
    p_q1     = CH_CR;
    p_q2     = CH_BS;
    p_cnt    = 2'd1;
    priority if (ch_r == CH_LF) begin
      p_ncol = '0;
      p_cnt  = 2'd2;
      if (row_r == RW'(ROWS - 1)) p_scroll = 1'b1;
      else                        p_nrow   = RW'(row_r + 1'b1);
    end else if (ch_r == CH_BS) begin
      p_q1   = CH_SP;
      p_q2   = CH_BS;
      p_data = CH_SP;
      if (col_r != '0) begin
        p_tcol  = CW'(col_r - 1'b1);
        p_write = 1'b1;
        p_cnt   = 2'd3;
      end else if (row_r != '0) begin
        p_trow  = RW'(row_r - 1'b1);
        p_tcol  = CW'(COLS - 1);
        p_write = 1'b1;
        p_cnt   = 2'd3;
      end
      // at home nothing moves and only the BS itself is echoed
      p_nrow = p_trow;
      p_ncol = p_tcol;
    end else begin
      p_write = 1'b1;
      if (ch_r == CH_TAB) p_data = CH_SP;
      if (col_r == CW'(COLS - 1)) begin
        p_ncol = '0;
        if (row_r == RW'(ROWS - 1)) p_scroll = 1'b1;
        else                        p_nrow   = RW'(row_r + 1'b1);
      end else begin
        p_ncol = CW'(col_r + 1'b1);
      end
    end
  end

  // logical row -> row in the ring
  always_comb begin
    lrow = (cmd_r == CMD_READ) ? RW'(rrow_r) : p_trow;
    psum = {1'b0, base_r} + {1'b0, lrow};
    if (psum >= (RW+1)'(ROWS)) psum = psum - (RW+1)'(ROWS);
    phys_c = psum[RW-1:0];
  end

  assign sweep_done = (sweep_cnt_r == CW'(COLS - 1));

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    zero_row_nxt  = zero_row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.plan) begin
      unique case (cmd_r)
        CMD_PUT: begin
          row_nxt = p_nrow;
          col_nxt = p_ncol;
        end
        CMD_CLEAR: begin
          row_nxt      = '0;
          col_nxt      = '0;
          base_nxt     = '0;
          zero_row_nxt = '1;
        end
        default: ;
      endcase
    end
    if (cmd.scroll_set) begin
      base_nxt = (base_r == RW'(ROWS - 1)) ? '0 : RW'(base_r + 1'b1);
    end
    if (cmd.sweep_step && sweep_done) zero_row_nxt[sweep_row_r] = 1'b0;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      zero_row_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      zero_row_r  <= zero_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= in_command;
      ch_r   <= in_char_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (cmd.plan) begin
      unique case (cmd_r)
        CMD_PUT: begin
          phys_r   <= phys_c;
          tcol_r   <= p_tcol;
          wdata_r  <= p_data;
          scroll_r <= p_scroll;
          q_r[0]   <= p_q0;
          q_r[1]   <= p_q1;
          q_r[2]   <= p_q2;
          qcnt_r   <= p_cnt;
          qidx_r   <= '0;
          qkind_r  <= KIND_ECHO;
        end
        CMD_CLEAR: begin
          q_r[0]  <= CH_NUL;
          qcnt_r  <= 2'd1;
          qidx_r  <= '0;
          qkind_r <= KIND_CLEAR;
        end
        CMD_READ: begin
          phys_r <= phys_c;
          tcol_r <= CW'(rcol_r);
          oor_r  <= (int'(rrow_r) >= ROWS) || (int'(rcol_r) >= COLS);
        end
        default: ;
      endcase
    end
    if (cmd.row_sel) begin
      rowbase_r   <= AW'(phys_r) * AW'(COLS);
      sweep_cnt_r <= '0;
      sweep_row_r <= phys_r;
      fill_r      <= CH_NUL;
    end
    if (cmd.scroll_set) begin
      // old top row becomes the new bottom row, blanked with spaces
      rowbase_r   <= AW'(base_r) * AW'(COLS);
      sweep_cnt_r <= '0;
      sweep_row_r <= base_r;
      fill_r      <= CH_SP;
    end
    if (cmd.sweep_step) sweep_cnt_r <= CW'(sweep_cnt_r + 1'b1);
    if (cmd.rd_load) begin
      q_r[0]  <= (oor_r || zero_row_r[phys_r]) ? CH_NUL : rdata_r;
      qcnt_r  <= 2'd1;
      qidx_r  <= '0;
      qkind_r <= KIND_READ;
    end
    if (cmd.emit) begin
      out_kind_r <= qkind_r;
      out_byte_r <= q_r[qidx_r];
      out_row_r  <= ROW_W'(row_r);
      out_col_r  <= COL_W'(col_r);
      out_last_r <= (qidx_r == qcnt_r - 2'd1);
      qidx_r     <= qidx_r + 2'd1;
    end
  end

  // screen memory: one write port, one registered read port
  always_comb begin
    mem_we    = cmd.sweep_step || cmd.write_cell;
    mem_waddr = cmd.sweep_step ? AW'(rowbase_r + AW'(sweep_cnt_r))
                               : AW'(rowbase_r + AW'(tcol_r));
    mem_wdata = cmd.sweep_step ? fill_r : wdata_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) rdata_r <= mem[AW'(rowbase_r + AW'(tcol_r))];
  end

  always_comb begin
    sts             = '0;
    sts.cmd         = cmd_r;
    sts.put_write   = p_write;
    sts.put_scroll  = p_scroll;
    sts.scroll_pend = scroll_r;
    sts.row_zero    = zero_row_r[phys_r];
    sts.sweep_done  = sweep_done;
    sts.out_free    = !out_valid_r || out_ready;
    sts.q_last      = (qidx_r == qcnt_r - 2'd1);
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_byte_value  = out_byte_r;
  assign out_cursor_row  = out_row_r;
  assign out_cursor_col  = out_col_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/text_console_cursor_engine.sv
// Order from input transfer to first result: a put with a cell write passes row select, a
// zero fill of a target row unwritten since clear/reset, the cell write and, on a scroll,
// the blanking sweep; other puts scroll or emit at once; a read passes row select, a memory
// read and a data load; a clear emits at once. Further echo bytes follow as the output frees.
// One item at a time: the next input waits for the last result to reach the output register.
// Reset (rst_n, synchronous): cursor home, output empty, every row flagged as reading zero.
`default_nettype none

module text_console_cursor_engine #(
  parameter int COLS = tcc_pkg::DEF_COLS,
  parameter int ROWS = tcc_pkg::DEF_ROWS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcc_in_if.sink     in_ch,
  tcc_out_if.source  out_ch
);
  import tcc_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  tcc_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_command      (in_ch.command),
    .in_char_code    (in_ch.char_code),
    .in_read_row     (in_ch.read_row),
    .in_read_col     (in_ch.read_col),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_result_kind (out_ch.result_kind),
    .out_byte_value  (out_ch.byte_value),
    .out_cursor_row  (out_ch.cursor_row),
    .out_cursor_col  (out_ch.cursor_col),
    .out_last        (out_ch.last)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcc_pkg::*;

  localparam int COLS = DEF_COLS;
  localparam int ROWS = DEF_ROWS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 250;
  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    kind_t kind;
    byte_t value;
    row_t  row;
    col_t  col;
    logic  last;
  } console_result_t;

  class console_scoreboard;
    byte_t screen[ROWS][COLS];
    int unsigned cur_row;
    int unsigned cur_col;
    console_result_t expected_results[$];
    int unsigned accepted;
    int unsigned mismatch_count;

    function void clear_screen();
      foreach (screen[r, c]) screen[r][c] = CH_NUL;
      cur_row = 0;
      cur_col = 0;
    endfunction

    function void push_result(kind_t kind, byte_t value, bit last_flag);
      console_result_t res;
      res.kind  = kind;
      res.value = value;
      res.row   = row_t'(cur_row);
      res.col   = col_t'(cur_col);
      res.last  = last_flag;
      expected_results.push_back(res);
    endfunction

    function void apply_put(byte_t ch);
      byte_t tail[$];
      bit moved;
      moved = 1'b1;
      if (ch == CH_LF) begin
        cur_col = 0;
        cur_row++;
        tail.push_back(CH_CR);
      end else if (ch == CH_BS) begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLS - 1;
        end else begin
          moved = 1'b0;  // at home: only the BS itself is echoed
        end
        if (moved) begin
          screen[cur_row][cur_col] = CH_SP;
          tail.push_back(CH_SP);
          tail.push_back(CH_BS);
        end
      end else begin
        screen[cur_row][cur_col] = (ch == CH_TAB) ? CH_SP : ch;
        cur_col++;
      end
      if (cur_col >= COLS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        for (int r = 0; r < ROWS - 1; r++) screen[r] = screen[r + 1];
        for (int c = 0; c < COLS; c++) screen[ROWS - 1][c] = CH_SP;
        cur_row = ROWS - 1;
      end
      push_result(KIND_ECHO, ch, tail.size() == 0);
      foreach (tail[i]) push_result(KIND_ECHO, tail[i], i == tail.size() - 1);
    endfunction

    function void note_command(cmd_t cmd, byte_t ch, row_t r, col_t c);
      byte_t cell_val;
      accepted++;
      case (cmd)
        CMD_PUT: begin
          apply_put(ch);
        end
        CMD_CLEAR: begin
          clear_screen();
          push_result(KIND_CLEAR, CH_NUL, 1'b1);
        end
        CMD_READ: begin
          cell_val = (r < ROWS && c < COLS) ? screen[r][c] : CH_NUL;
          push_result(KIND_READ, cell_val, 1'b1);
        end
        default: ;  // unused command: no result, no state change
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d byte 0x%0h", got.kind, got.value);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("byte_value", want.value, got.value);
      compare_field("cursor_row", want.row, got.row);
      compare_field("cursor_col", want.col, got.col);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit quiet;
  bit hold_done;
  int unsigned idle_count;
  int unsigned stall_left;
  console_scoreboard sb;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();

  text_console_cursor_engine #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    console_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind  = out_ch.result_kind;
      got.value = out_ch.byte_value;
      got.row   = out_ch.cursor_row;
      got.col   = out_ch.cursor_col;
      got.last  = out_ch.last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off while the sender keeps offering
  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (!hold_done && sb.accepted >= 40) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_command(cmd_t cmd, byte_t ch, row_t r, col_t c);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.char_code <= ch;
    in_ch.read_row  <= r;
    in_ch.read_col  <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(cmd, ch, r, c);
  endtask

  task automatic put_char(byte_t ch);
    send_command(CMD_PUT, ch, row_t'($urandom), col_t'($urandom));
  endtask

  task automatic read_cell(row_t r, col_t c);
    send_command(CMD_READ, byte_t'($urandom), r, c);
  endtask

  function automatic byte_t pick_char();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 22) return CH_LF;
    if (k < 34) return CH_BS;
    if (k < 40) return CH_TAB;
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic random_read();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      read_cell(row_t'(sb.cur_row), col_t'($urandom_range(0, COLS - 1)));
    end else if (k < 8) begin
      read_cell(row_t'($urandom_range(0, ROWS - 1)), col_t'($urandom_range(0, COLS - 1)));
    end else begin
      read_cell(row_t'($urandom), col_t'($urandom));
    end
  endtask

  initial begin
    int unsigned k;
    sb = new();
    sb.clear_screen();
    quiet = 1'b0;
    hold_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_PUT;
    in_ch.char_code <= CH_NUL;
    in_ch.read_row  <= '0;
    in_ch.read_col  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    put_char(CH_BS);           // backspace at home
    read_cell('0, '0);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_TAB);
    read_cell('0, col_t'(3));
    put_char(CH_BS);
    put_char(CH_LF);
    put_char(CH_BS);           // wraps back to last column of row 0
    read_cell('0, col_t'(COLS - 1));
    put_char(8'h7A);           // fills last column, cursor wraps
    read_cell(5'd31, '0);
    read_cell('0, 7'd127);
    read_cell(row_t'(ROWS - 1), col_t'(COLS - 1));
    read_cell(row_t'(ROWS), col_t'(COLS));
    send_command(CMD_UNUSED, 8'hA5, 5'h1F, 7'h7F);
    put_char(8'h7F);
    read_cell('0, '0);
    send_command(CMD_CLEAR, 8'hFF, 5'h1F, 7'h7F);
    read_cell('0, col_t'(1));
    put_char(CH_BS);

    // run down past the bottom row so the screen scrolls
    for (int i = 0; i < 33; i++) begin
      if (i % 9 == 0) put_char(byte_t'($urandom_range(8'h21, 8'h7E)));
      else put_char(CH_LF);
    end
    read_cell(row_t'(ROWS - 1), '0);
    read_cell(row_t'(ROWS - 2), '0);

    // long line along the bottom row: wraps at the line end and scrolls
    repeat (COLS + 3) put_char(byte_t'($urandom_range(8'h20, 8'hFE)));

    for (int i = 0; i < 70; i++) begin
      if (i == 55) quiet = 1'b1;
      k = $urandom_range(0, 99);
      if (k < 74) put_char(pick_char());
      else if (k < 92) random_read();
      else if (k < 95) send_command(CMD_CLEAR, byte_t'($urandom), row_t'($urandom),
                                    col_t'($urandom));
      else send_command(CMD_UNUSED, byte_t'($urandom), row_t'($urandom),
                        col_t'($urandom));
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: text_console_cursor_engine.f
rtl/core/tcc_pkg.sv
rtl/core/tcc_if.sv
rtl/core/tcc_ctrl.sv
rtl/core/tcc_dp.sv
rtl/core/text_console_cursor_engine.sv
bench/tb.sv
